>>> sv/abz_pkg.sv
package abz_pkg;

    // CORDIC depth and word width (amplitude 2^30 with headroom).
    localparam int CORDIC_STEPS = 30;
    localparam int CW = 33;

    localparam logic signed [CW-1:0] CORDIC_GAIN_INV = 33'sd652032874;
    localparam logic [15:0] RATIO_RESET = 16'd25821;
    localparam logic [14:0] QUARTER_TURN = 15'd16384;
    localparam logic [16:0] FULL_TURN = 17'd65536;

    // Which angle of a segment a CORDIC request carries.
    typedef enum logic [1:0] {
        TAG_START = 2'd0,
        TAG_END   = 2'd1,
        TAG_HALF  = 2'd2
    } tag_t;

    // Data handed from one rotation cell to the next.
    typedef struct packed {
        logic              valid;
        tag_t              tag;
        logic [1:0]        quad;
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [CW-1:0] z;
    } cell_bus_t;

    // Arctangent of 2^-i in units of 2^32 per turn.
    function automatic logic signed [CW-1:0] atan_turn(input int idx);
        logic signed [CW-1:0] v;
        case (idx)
            0:  v = 33'sd536870912;
            1:  v = 33'sd316933406;
            2:  v = 33'sd167458907;
            3:  v = 33'sd85004756;
            4:  v = 33'sd42667331;
            5:  v = 33'sd21354465;
            6:  v = 33'sd10679838;
            7:  v = 33'sd5340245;
            8:  v = 33'sd2670163;
            9:  v = 33'sd1335087;
            10: v = 33'sd667544;
            11: v = 33'sd333772;
            12: v = 33'sd166886;
            13: v = 33'sd83443;
            14: v = 33'sd41722;
            15: v = 33'sd20861;
            16: v = 33'sd10430;
            17: v = 33'sd5215;
            18: v = 33'sd2608;
            19: v = 33'sd1304;
            20: v = 33'sd652;
            21: v = 33'sd326;
            22: v = 33'sd163;
            23: v = 33'sd81;
            24: v = 33'sd41;
            25: v = 33'sd20;
            26: v = 33'sd10;
            27: v = 33'sd5;
            28: v = 33'sd3;
            29: v = 33'sd1;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

>>> sv/abz_cell.sv
module abz_cell
    import abz_pkg::*;
#(
    parameter int STAGE = 0
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  cell_bus_t din,
    output cell_bus_t dout
);

    cell_bus_t bus_next;
    cell_bus_t bus_reg;
    logic signed [CW-1:0] dx;
    logic signed [CW-1:0] dy;
    logic signed [CW-1:0] at;

    // One CORDIC rotation toward zero residual angle.
    always_comb
    begin
        dx = din.x >>> STAGE;
        dy = din.y >>> STAGE;
        at = atan_turn(STAGE);
        bus_next = din;
        if (din.z >= 0)
        begin
            bus_next.x = din.x - dy;
            bus_next.y = din.y + dx;
            bus_next.z = din.z - at;
        end
        else
        begin
            bus_next.x = din.x + dy;
            bus_next.y = din.y - dx;
            bus_next.z = din.z + at;
        end
    end

    // Stage register; reset empties the cell.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bus_reg <= '0;
        end
        else
        begin
            bus_reg <= bus_next;
        end
    end

    assign dout = bus_reg;

endmodule

>>> sv/abz_cordic.sv
module abz_cordic
    import abz_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    input  tag_t              req_tag,
    input  logic [31:0]       req_angle,
    output logic              res_valid,
    output tag_t              res_tag,
    output logic signed [CW-1:0] res_cos,
    output logic signed [CW-1:0] res_sin
);

    cell_bus_t bus [0:CORDIC_STEPS];
    cell_bus_t last;

    // Seed the chain with the folded first-quadrant angle.
    assign bus[0] = '{valid: req_valid,
                      tag:   req_tag,
                      quad:  req_angle[31:30],
                      x:     CORDIC_GAIN_INV,
                      y:     '0,
                      z:     {3'b000, req_angle[29:0]}};

    genvar i;
    generate
        for (i = 0; i < CORDIC_STEPS; i++)
        begin : g_cell
            abz_cell #(.STAGE(i)) u_cell
            (
                .clk  (clk),
                .rst_n(rst_n),
                .din  (bus[i]),
                .dout (bus[i+1])
            );
        end
    endgenerate

    // Rotate the result back into its quadrant.
    always_comb
    begin
        last = bus[CORDIC_STEPS];
        res_valid = last.valid;
        res_tag   = last.tag;
        case (last.quad)
            2'd0:
            begin
                res_cos = last.x;
                res_sin = last.y;
            end
            2'd1:
            begin
                res_cos = -last.y;
                res_sin = last.x;
            end
            2'd2:
            begin
                res_cos = -last.x;
                res_sin = -last.y;
            end
            default:
            begin
                res_cos = last.y;
                res_sin = -last.x;
            end
        endcase
    end

endmodule

>>> sv/arc_to_bezier_segmenter_unit.sv
// Arc to cubic Bezier segmenter.
// A request is taken at a clock edge with start high and busy low; it carries
// center, radius, start and end angle and the direction. The block then
// produces one to four segments in sweep order. Each segment appears on the
// result ports for exactly one cycle with result_valid high, and last_segment
// marks the final one. The receiver cannot stall, so nothing waits on it.
// The handle ratio is to be written through cfg_we and cfg_wdata while idle;
// the user must keep to this, as the block does not enforce it. Per segment
// three angles are fed in turn through a 30-cell CORDIC chain, then ten
// products go through one shared multiplier, each as a multiply and then a
// rounding step, and the points are summed into the output registers. Busy
// falls when the last segment is shown, and a new request can be taken at
// that edge. Reset clears the sequencer and the chain and restores the
// default ratio.
module arc_to_bezier_segmenter_unit
    import abz_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               cfg_we,
    input  logic [15:0]        cfg_wdata,
    input  logic signed [31:0] center_x,
    input  logic signed [31:0] center_y,
    input  logic [15:0]        angle_from,
    input  logic [15:0]        angle_to,
    input  logic [30:0]        radius,
    input  logic               clockwise,
    output logic               result_valid,
    output logic signed [31:0] seg_start_x,
    output logic signed [31:0] seg_start_y,
    output logic signed [31:0] ctrl_one_x,
    output logic signed [31:0] ctrl_one_y,
    output logic signed [31:0] ctrl_two_x,
    output logic signed [31:0] ctrl_two_y,
    output logic signed [31:0] seg_end_x,
    output logic signed [31:0] seg_end_y,
    output logic               last_segment
);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_FEED = 5'b00010,
        S_WAIT = 5'b00100,
        S_MUL  = 5'b01000,
        S_EMIT = 5'b10000
    } state_t;

    localparam logic [3:0] OP_CHORD  = 4'd0;
    localparam logic [3:0] OP_HANDLE = 4'd1;
    localparam logic [3:0] OP_RC0    = 4'd2;
    localparam logic [3:0] OP_RS0    = 4'd3;
    localparam logic [3:0] OP_RC1    = 4'd4;
    localparam logic [3:0] OP_RS1    = 4'd5;
    localparam logic [3:0] OP_HS0N   = 4'd6;
    localparam logic [3:0] OP_HC0    = 4'd7;
    localparam logic [3:0] OP_HS1    = 4'd8;
    localparam logic [3:0] OP_HC1N   = 4'd9;

    state_t state_reg;
    logic [15:0] ratio_reg;
    logic signed [31:0] cx_reg, cy_reg;
    logic [30:0] r_reg;
    logic cw_reg;
    logic [15:0] ang_reg;
    logic [14:0] step_reg;
    logic [1:0] seg_reg;
    logic [2:0] nseg_reg;
    logic [1:0] feed_reg;
    logic [3:0] op_reg;
    logic phase_reg;
    logic signed [CW-1:0] c0_reg, s0_reg, c1_reg, s1_reg, hs_reg;
    logic signed [66:0] prod_reg;
    logic [31:0] chord_reg;
    logic signed [32:0] h_reg;
    logic signed [31:0] rc0_reg, rs0_reg, rc1_reg, rs1_reg;
    logic signed [31:0] hs0n_reg, hc0_reg, hs1_reg, hc1n_reg;
    logic result_valid_reg;
    logic signed [31:0] o_sx_reg, o_sy_reg, o_c1x_reg, o_c1y_reg;
    logic signed [31:0] o_c2x_reg, o_c2y_reg, o_ex_reg, o_ey_reg;
    logic o_last_reg;

    logic [15:0] diff16;
    logic [16:0] diff17;
    logic [14:0] step_init;
    logic [16:0] span;
    logic [2:0]  nseg_init;
    logic [15:0] a1;
    logic        req_valid;
    tag_t        req_tag;
    logic [31:0] req_angle;
    logic        res_valid;
    tag_t        res_tag;
    logic signed [CW-1:0] res_cos, res_sin;
    logic signed [33:0] opa;
    logic signed [32:0] opb;
    logic signed [66:0] rnd;
    logic signed [31:0] p0x, p0y, p3x, p3y;
    logic is_last;

    // Sweep length, first step and segment count of a new request.
    always_comb
    begin
        diff16 = clockwise ? (angle_from - angle_to) : (angle_to - angle_from);
        diff17 = (diff16 == 16'd0) ? FULL_TURN : {1'b0, diff16};
        step_init = (diff17[13:0] == 14'd0) ? QUARTER_TURN : {1'b0, diff17[13:0]};
        span = diff17 - {2'b00, step_init};
        nseg_init = {1'b0, span[15:14]} + 3'd1;
    end

    assign a1 = cw_reg ? (ang_reg - {1'b0, step_reg}) : (ang_reg + {1'b0, step_reg});

    // Angle requests into the CORDIC chain.
    always_comb
    begin
        req_valid = (state_reg == S_FEED);
        case (feed_reg)
            2'd0:
            begin
                req_tag = TAG_START;
                req_angle = {ang_reg, 16'd0};
            end
            2'd1:
            begin
                req_tag = TAG_END;
                req_angle = {a1, 16'd0};
            end
            default:
            begin
                req_tag = TAG_HALF;
                req_angle = {2'b00, step_reg, 15'd0};
            end
        endcase
    end

    abz_cordic u_cordic
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .req_valid(req_valid),
        .req_tag  (req_tag),
        .req_angle(req_angle),
        .res_valid(res_valid),
        .res_tag  (res_tag),
        .res_cos  (res_cos),
        .res_sin  (res_sin)
    );

    // Operand selection for the shared multiplier.
    always_comb
    begin
        case (op_reg)
            OP_CHORD:
            begin
                opa = {2'b00, r_reg, 1'b0};
                opb = hs_reg;
            end
            OP_HANDLE:
            begin
                opa = {2'b00, chord_reg};
                opb = {17'd0, ratio_reg};
            end
            OP_RC0:
            begin
                opa = {3'b000, r_reg};
                opb = c0_reg;
            end
            OP_RS0:
            begin
                opa = {3'b000, r_reg};
                opb = s0_reg;
            end
            OP_RC1:
            begin
                opa = {3'b000, r_reg};
                opb = c1_reg;
            end
            OP_RS1:
            begin
                opa = {3'b000, r_reg};
                opb = s1_reg;
            end
            OP_HS0N:
            begin
                opa = {h_reg[32], h_reg};
                opb = -s0_reg;
            end
            OP_HC0:
            begin
                opa = {h_reg[32], h_reg};
                opb = c0_reg;
            end
            OP_HS1:
            begin
                opa = {h_reg[32], h_reg};
                opb = s1_reg;
            end
            default:
            begin
                opa = {h_reg[32], h_reg};
                opb = -c1_reg;
            end
        endcase
        if (op_reg == OP_HANDLE)
        begin
            rnd = (prod_reg + 67'sd32768) >>> 16;
        end
        else
        begin
            rnd = (prod_reg + 67'sd536870912) >>> 30;
        end
    end

    // Segment points from the stored products.
    always_comb
    begin
        p0x = cx_reg + rc0_reg;
        p0y = cy_reg + rs0_reg;
        p3x = cx_reg + rc1_reg;
        p3y = cy_reg + rs1_reg;
        is_last = (({1'b0, seg_reg} + 3'd1) == nseg_reg);
    end

    // Sequencer and configuration register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ratio_reg <= RATIO_RESET;
            feed_reg <= 2'd0;
            op_reg <= OP_CHORD;
            phase_reg <= 1'b0;
            seg_reg <= 2'd0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            result_valid_reg <= (state_reg == S_EMIT);
            if (cfg_we)
            begin
                ratio_reg <= cfg_wdata;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        state_reg <= S_FEED;
                        feed_reg <= 2'd0;
                        seg_reg <= 2'd0;
                    end
                end
                S_FEED:
                begin
                    feed_reg <= feed_reg + 2'd1;
                    if (feed_reg == 2'd2)
                    begin
                        state_reg <= S_WAIT;
                    end
                end
                S_WAIT:
                begin
                    if (res_valid && res_tag == TAG_HALF)
                    begin
                        state_reg <= S_MUL;
                        op_reg <= OP_CHORD;
                        phase_reg <= 1'b0;
                    end
                end
                S_MUL:
                begin
                    phase_reg <= ~phase_reg;
                    if (phase_reg)
                    begin
                        if (op_reg == OP_HC1N)
                        begin
                            state_reg <= S_EMIT;
                        end
                        else
                        begin
                            op_reg <= op_reg + 4'd1;
                        end
                    end
                end
                S_EMIT:
                begin
                    if (is_last)
                    begin
                        state_reg <= S_IDLE;
                    end
                    else
                    begin
                        state_reg <= S_FEED;
                        feed_reg <= 2'd0;
                        seg_reg <= seg_reg + 2'd1;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // Request fields, CORDIC results, products and outputs.
    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && start)
        begin
            cx_reg <= center_x;
            cy_reg <= center_y;
            r_reg <= radius;
            cw_reg <= clockwise;
            ang_reg <= angle_from;
            step_reg <= step_init;
            nseg_reg <= nseg_init;
        end
        if (state_reg == S_EMIT)
        begin
            ang_reg <= a1;
            step_reg <= QUARTER_TURN;
            o_sx_reg <= p0x;
            o_sy_reg <= p0y;
            o_c1x_reg <= p0x + hs0n_reg;
            o_c1y_reg <= p0y + hc0_reg;
            o_c2x_reg <= p3x + hs1_reg;
            o_c2y_reg <= p3y + hc1n_reg;
            o_ex_reg <= p3x;
            o_ey_reg <= p3y;
            o_last_reg <= is_last;
        end
        if (res_valid)
        begin
            case (res_tag)
                TAG_START:
                begin
                    c0_reg <= res_cos;
                    s0_reg <= res_sin;
                end
                TAG_END:
                begin
                    c1_reg <= res_cos;
                    s1_reg <= res_sin;
                end
                default:
                begin
                    hs_reg <= res_sin;
                end
            endcase
        end
        if (state_reg == S_MUL)
        begin
            if (!phase_reg)
            begin
                prod_reg <= opa * opb;
            end
            else
            begin
                case (op_reg)
                    OP_CHORD:  chord_reg <= rnd[66] ? 32'd0 : rnd[31:0];
                    OP_HANDLE: h_reg <= cw_reg ? -rnd[32:0] : rnd[32:0];
                    OP_RC0:    rc0_reg <= rnd[31:0];
                    OP_RS0:    rs0_reg <= rnd[31:0];
                    OP_RC1:    rc1_reg <= rnd[31:0];
                    OP_RS1:    rs1_reg <= rnd[31:0];
                    OP_HS0N:   hs0n_reg <= rnd[31:0];
                    OP_HC0:    hc0_reg <= rnd[31:0];
                    OP_HS1:    hs1_reg <= rnd[31:0];
                    default:   hc1n_reg <= rnd[31:0];
                endcase
            end
        end
    end

    assign busy = (state_reg != S_IDLE);
    assign result_valid = result_valid_reg;
    assign seg_start_x = o_sx_reg;
    assign seg_start_y = o_sy_reg;
    assign ctrl_one_x = o_c1x_reg;
    assign ctrl_one_y = o_c1y_reg;
    assign ctrl_two_x = o_c2x_reg;
    assign ctrl_two_y = o_c2y_reg;
    assign seg_end_x = o_ex_reg;
    assign seg_end_y = o_ey_reg;
    assign last_segment = o_last_reg;

endmodule

>>> sv/abz_monitor.sv
module abz_monitor
(
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic result_valid,
    input logic last_segment
);

    // An accepted request keeps the block busy in the next cycle.
    a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("busy low after accepted request");

    // Segments are spaced out; two never come in adjacent cycles.
    a_no_adjacent: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |=> !result_valid)
        else $error("results in adjacent cycles");

    // The final segment of an arc coincides with the block going idle.
    a_idle_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && last_segment) |-> !busy)
        else $error("busy while final segment shown");

    // A segment never follows straight after the request that causes it.
    a_no_instant: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> !result_valid)
        else $error("result right after request");

endmodule

bind arc_to_bezier_segmenter_unit abz_monitor u_abz_monitor (.*);
